/* src/fgd_pkg.sv */
// Package for the fixed frame GPIO deframer.
// Holds deframer phase type, item kind codes, register indexes and widths.
// No dependencies.
package fgd_pkg;

	// Deframer phase
	typedef enum logic [1:0] {
		PH_WAIT_HDR = 2'd0,
		PH_PAYLOAD  = 2'd1,
		PH_WAIT_END = 2'd2
	} phase_t;

	// Item kind carried by the mode field
	localparam logic MODE_BYTE = 1'b0;
	localparam logic MODE_TICK = 1'b1;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t REG_HEADER_BYTE = 2'd0;
	localparam cfg_idx_t REG_END_BYTE    = 2'd1;
	localparam cfg_idx_t REG_TIMEOUT_MS  = 2'd2;

	localparam int unsigned CFG_DATA_W = 16;

	// Frame layout
	localparam int unsigned PAY_LEN   = 4;
	localparam int unsigned PAY_IDX_W = 2;
	typedef logic [PAY_IDX_W-1:0] pay_idx_t;

	// Reset values of the configuration registers
	localparam logic [7:0]            HEADER_RST  = 8'hAA;
	localparam logic [7:0]            END_RST     = 8'h55;
	localparam logic [CFG_DATA_W-1:0] TIMEOUT_RST = 16'd1000;

endpackage

/* src/fixed_frame_gpio_deframer.sv */
// Fixed frame GPIO deframer, top level.
// Path from input transaction to result: input register, then result register.
// One item per cycle unless a result is stalled; exactly one result per transaction.
// The rate is set by the single deframer/counter update between the two register stages.
// Reset (arst_n, asynchronous, active low): deframer waits for header, image, counters
// and time clear, config registers take header 0xAA, end 0x55, timeout 1000 ms.
// Depends on fgd_pkg.
module fixed_frame_gpio_deframer
	import fgd_pkg::*;
#(
	parameter int unsigned GPIO_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write port
	input  logic                  cfg_we,
	input  cfg_idx_t              cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// input channel
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  mode,
	input  logic [7:0]            rx_byte,
	// result channel
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [31:0]           gpio_bits,
	output logic [31:0]           packet_total,
	output logic [31:0]           last_packet_time,
	output logic                  online,
	output logic                  frame_done,
	output logic                  framing_error
);

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [7:0]            header_q;
	logic [7:0]            end_q;
	logic [CFG_DATA_W-1:0] timeout_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q  <= HEADER_RST;
			end_q     <= END_RST;
			timeout_q <= TIMEOUT_RST;
		end else if (cfg_we) begin
			// Out-of-range indexes fall through and are ignored
			if (cfg_index == REG_HEADER_BYTE) begin
				header_q <= cfg_data[7:0];
			end
			if (cfg_index == REG_END_BYTE) begin
				end_q <= cfg_data[7:0];
			end
			if (cfg_index == REG_TIMEOUT_MS) begin
				timeout_q <= cfg_data;
			end
		end
	end

	// ------------------------------------------------------------------
	// Flow control: the whole pipe advances unless a result sits unclaimed
	// on a stalled output. The input stage refills in the same cycle the
	// result register drains, so one transaction per cycle flows through.
	// ------------------------------------------------------------------
	logic advance;
	logic out_valid_q;

	assign advance  = !(out_valid_q && out_stall);
	assign in_stall = !advance;

	// Input register
	logic       valid_s1;
	logic       mode_s1;
	logic [7:0] byte_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			mode_s1 <= mode;
			byte_s1 <= rx_byte;
		end
	end

	// ------------------------------------------------------------------
	// Deframer and bookkeeping state
	// ------------------------------------------------------------------
	phase_t               phase_q, phase_d;
	pay_idx_t             idx_q, idx_d;
	logic [7:0]           payload_q [PAY_LEN];
	logic [31:0]          image_q, image_d;
	logic [31:0]          count_q, count_d;
	logic [31:0]          last_q, last_d;
	logic [31:0]          time_q, time_d;
	logic                 pay_we;
	logic                 done_d;
	logic                 ferr_d;
	logic                 online_d;
	logic                 proc;
	logic [PAY_LEN*8-1:0] frame_word;
	logic [31:0]          elapsed;

	assign proc = valid_s1 && advance;

	// Payload byte 0 lands in bits 7:0; narrow GPIO keeps the low bits only
	assign frame_word = {payload_q[3], payload_q[2], payload_q[1], payload_q[0]};

	always_comb begin
		phase_d = phase_q;
		idx_d   = idx_q;
		image_d = image_q;
		count_d = count_q;
		last_d  = last_q;
		time_d  = time_q;
		pay_we  = 1'b0;
		done_d  = 1'b0;
		ferr_d  = 1'b0;
		if (proc) begin
			if (mode_s1 == MODE_TICK) begin
				// Advance the wrapping millisecond clock; deframer holds
				time_d = time_q + 32'd1;
			end else begin
				unique case (phase_q)
					PH_WAIT_HDR: begin
						if (byte_s1 == header_q) begin
							idx_d   = '0;
							phase_d = PH_PAYLOAD;
						end
					end
					PH_PAYLOAD: begin
						pay_we = 1'b1;
						idx_d  = idx_q + pay_idx_t'(1);
						if (idx_q == pay_idx_t'(PAY_LEN - 1)) begin
							phase_d = PH_WAIT_END;
						end
					end
					PH_WAIT_END: begin
						if (byte_s1 == end_q) begin
							// Commit the frame; image bits above GPIO_BITS stay zero
							image_d = 32'(frame_word[GPIO_BITS-1:0]);
							count_d = count_q + 32'd1;
							last_d  = time_q;
							done_d  = 1'b1;
						end else begin
							// Wrong end byte: drop the frame
							ferr_d = 1'b1;
						end
						phase_d = PH_WAIT_HDR;
					end
					default: begin
						phase_d = PH_WAIT_HDR;
					end
				endcase
			end
		end
		// Online test uses the state after this item; time difference wraps
		elapsed  = time_d - last_d;
		online_d = elapsed < {16'd0, timeout_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT_HDR;
			idx_q   <= '0;
			image_q <= '0;
			count_q <= '0;
			last_q  <= '0;
			time_q  <= '0;
		end else begin
			phase_q <= phase_d;
			idx_q   <= idx_d;
			image_q <= image_d;
			count_q <= count_d;
			last_q  <= last_d;
			time_q  <= time_d;
		end
	end

	// Payload bytes reset to zero, matching a commit before any payload arrived
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PAY_LEN; i++) begin
				payload_q[i] <= '0;
			end
		end else if (pay_we) begin
			payload_q[idx_q] <= byte_s1;
		end
	end

	// ------------------------------------------------------------------
	// Result register
	// ------------------------------------------------------------------
	logic [31:0]          gpio_q;
	logic [31:0]          total_q;
	logic [31:0]          ptime_q;
	logic                 online_q;
	logic                 done_q;
	logic                 ferr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			gpio_q   <= image_d;
			total_q  <= count_d;
			ptime_q  <= last_d;
			online_q <= online_d;
			done_q   <= done_d;
			ferr_q   <= ferr_d;
		end
	end

	assign out_valid        = out_valid_q;
	assign gpio_bits        = gpio_q;
	assign packet_total     = total_q;
	assign last_packet_time = ptime_q;
	assign online           = online_q;
	assign frame_done       = done_q;
	assign framing_error    = ferr_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------

	// A committed frame bumps the packet count by exactly one
	a_commit_counts: assert property (@(posedge clk) disable iff (!arst_n)
		proc && done_d |=> count_q == $past(count_q) + 32'd1)
		else $error("packet count did not advance on commit");

	// A tick never moves the deframer
	a_tick_holds_phase: assert property (@(posedge clk) disable iff (!arst_n)
		proc && (mode_s1 == MODE_TICK) |=> phase_q == $past(phase_q) && idx_q == $past(idx_q))
		else $error("deframer moved on a tick");

	// A reported good frame carries the stored time of the last good frame
	a_done_time: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && done_q |-> ptime_q == last_q)
		else $error("frame time does not match stored time");

	// Done and framing error come only from the end-byte check, never together
	a_done_excl: assert property (@(posedge clk) disable iff (!arst_n)
		proc && (done_d || ferr_d) |-> phase_q == PH_WAIT_END && !(done_d && ferr_d))
		else $error("frame outcome outside end-byte check");

endmodule

/* tb/tb_fixed_frame_gpio_deframer.sv */
// Self-checking testbench for fixed_frame_gpio_deframer: a directed script and then random
// frame, noise and tick traffic under random sender gaps and receiver stalls.
// Depends on fgd_pkg and the deframer RTL; each result is checked against a local predictor or a typed script row.
module tb_fixed_frame_gpio_deframer;
	import fgd_pkg::*;

	localparam int HALF_PERIOD   = 4;
	localparam int LIMIT_CYCLES  = 400000;
	localparam int HOLD_CYCLES   = 80;
	localparam int PHASE_ITEMS   = 325;
	localparam int MAX_PRINTS    = 40;
	// Index 3 decodes to no register; writes there must leave every setting alone.
	localparam cfg_idx_t REG_UNUSED = 2'd3;

	// One result as the block reports it
	typedef struct packed {
		logic [31:0] gpio;
		logic [31:0] total;
		logic [31:0] last_ms;
		logic        online;
		logic        done;
		logic        ferr;
	} status_t;

	// One row of the directed script; want is used only when typed is set
	typedef struct {
		logic       m;
		logic [7:0] b;
		bit         typed;
		status_t    want;
	} stim_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	cfg_idx_t              cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic                  mode;
	logic [7:0]            rx_byte;
	logic                  out_valid;
	logic                  out_stall;
	logic [31:0]           gpio_bits;
	logic [31:0]           packet_total;
	logic [31:0]           last_packet_time;
	logic                  online;
	logic                  frame_done;
	logic                  framing_error;

	// Shadow of the block: settings and deframer state
	logic [7:0]  want_hdr;
	logic [7:0]  want_end;
	logic [15:0] want_timeout;
	phase_t      dfr_phase;
	int          dfr_count;
	logic [7:0]  dfr_bytes [PAY_LEN];
	logic [31:0] image;
	logic [31:0] frames_ok;
	logic [31:0] last_ok_ms;
	logic [31:0] now_ms;

	status_t   pending_status [$];
	stim_row_t script [$];

	int errors      = 0;
	int results_in  = 0;
	int burst_left  = 0;
	int hold_asks   = 0;
	int hold_served = 0;
	int hold_left   = 0;
	int stall_style = 0;
	int rx_cycle    = 0;

	fixed_frame_gpio_deframer dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.mode             (mode),
		.rx_byte          (rx_byte),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.gpio_bits        (gpio_bits),
		.packet_total     (packet_total),
		.last_packet_time (last_packet_time),
		.online           (online),
		.frame_done       (frame_done),
		.framing_error    (framing_error)
	);

	always #HALF_PERIOD clk = ~clk;

	// Advance the shadow by one accepted transaction and return the status it should produce.
	function automatic status_t deframe_and_tally(input logic m, input logic [7:0] b);
		status_t s;
		logic [31:0] since;
		s = '0;
		if (m == MODE_TICK) begin
			now_ms = now_ms + 32'd1;
		end else begin
			case (dfr_phase)
				PH_WAIT_HDR: begin
					if (b == want_hdr) begin
						dfr_count = 0;
						dfr_phase = PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					dfr_bytes[dfr_count] = b;
					dfr_count++;
					if (dfr_count >= PAY_LEN)
						dfr_phase = PH_WAIT_END;
				end
				PH_WAIT_END: begin
					if (b == want_end) begin
						// Commit: payload byte 0 lands in the low GPIO bits
						image = {dfr_bytes[3], dfr_bytes[2], dfr_bytes[1], dfr_bytes[0]};
						frames_ok = frames_ok + 32'd1;
						last_ok_ms = now_ms;
						s.done = 1'b1;
					end else begin
						s.ferr = 1'b1;
					end
					dfr_phase = PH_WAIT_HDR;
				end
				default: dfr_phase = PH_WAIT_HDR;
			endcase
		end
		// Elapsed time wraps modulo 2^32; a zero timeout never reports online
		since = now_ms - last_ok_ms;
		s.gpio = image;
		s.total = frames_ok;
		s.last_ms = last_ok_ms;
		s.online = (since < {16'd0, want_timeout});
		return s;
	endfunction

	task report_bad(input string what, input logic [31:0] got, input logic [31:0] want);
		errors++;
		if (errors <= MAX_PRINTS)
			$display("MISMATCH result %0d %s: got %h want %h", results_in, what, got, want);
	endtask

	// Write one register; call only while the block is idle, right after a rising edge.
	task write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_HEADER_BYTE: want_hdr = val[7:0];
			REG_END_BYTE:    want_end = val[7:0];
			REG_TIMEOUT_MS:  want_timeout = val;
			default: ;
		endcase
	endtask

	// Offer one transaction; hold it until accepted, then record the expected status.
	task send_item(input logic m, input logic [7:0] b, input bit typed, input status_t want);
		status_t calc;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
			                                         : $urandom_range(1, 16);
		end
		in_valid <= 1'b1;
		mode <= m;
		rx_byte <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		calc = deframe_and_tally(m, b);
		pending_status.push_back(typed ? want : calc);
		burst_left--;
	endtask

	// Drop valid and wait until every expected status has come back.
	task settle;
		in_valid <= 1'b0;
		while (pending_status.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task row(input logic m, input logic [7:0] b, input bit typed, input logic [31:0] gpio,
	         input logic [31:0] total, input logic [31:0] last_ms, input logic on,
	         input logic done, input logic ferr);
		stim_row_t r;
		r.m = m;
		r.b = b;
		r.typed = typed;
		r.want = {gpio, total, last_ms, on, done, ferr};
		script.push_back(r);
	endtask

	// Mostly well-formed frames with ticks sprinkled in, plus noise bytes and tick runs.
	task run_traffic(input int n_items, input bit with_hold, input bit with_drain);
		int sent;
		int pick;
		int run;
		bit asked;
		bit drained;
		logic [7:0] b;
		sent = 0;
		asked = 0;
		drained = 0;
		while (sent < n_items) begin
			if (with_hold && !asked && sent >= n_items / 3) begin
				hold_asks++;
				asked = 1;
			end
			if (with_drain && !drained && sent >= 2 * n_items / 3) begin
				settle();
				drained = 1;
			end
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				for (int k = 0; k < 6; k++) begin
					if ($urandom_range(0, 4) == 0) begin
						send_item(MODE_TICK, 8'($urandom), 0, '0);
						sent++;
					end
					if (k == 0)
						b = want_hdr;
					else if (k < 5)
						b = 8'($urandom);
					else
						b = ($urandom_range(0, 6) == 0) ? 8'($urandom) : want_end;
					send_item(MODE_BYTE, b, 0, '0);
					sent++;
				end
			end else if (pick < 85) begin
				send_item(MODE_BYTE, 8'($urandom), 0, '0);
				sent++;
			end else begin
				run = $urandom_range(1, 40);
				repeat (run) begin
					send_item(MODE_TICK, 8'($urandom), 0, '0);
					sent++;
				end
			end
		end
	endtask

	// Receiver: draw stall patterns at random from four styles; serve long hold-off requests.
	always @(posedge clk) begin
		rx_cycle++;
		if (rx_cycle % 64 == 0)
			stall_style = $urandom_range(0, 3);
		if (hold_served != hold_asks) begin
			hold_served = hold_asks;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			case (stall_style)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 2) == 0);
				2: out_stall <= (rx_cycle % 5 == 0);
				default: out_stall <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	// Check each accepted result against the oldest pending status.
	always @(posedge clk) begin
		status_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_status.size() == 0) begin
				report_bad("result with nothing pending", gpio_bits, '0);
			end else begin
				want = pending_status.pop_front();
				if (gpio_bits !== want.gpio)
					report_bad("gpio_bits", gpio_bits, want.gpio);
				if (packet_total !== want.total)
					report_bad("packet_total", packet_total, want.total);
				if (last_packet_time !== want.last_ms)
					report_bad("last_packet_time", last_packet_time, want.last_ms);
				if (online !== want.online)
					report_bad("online", 32'(online), 32'(want.online));
				if (frame_done !== want.done)
					report_bad("frame_done", 32'(frame_done), 32'(want.done));
				if (framing_error !== want.ferr)
					report_bad("framing_error", 32'(framing_error), 32'(want.ferr));
			end
			results_in++;
		end
	end

	initial begin
		#(LIMIT_CYCLES * 2 * HALF_PERIOD);
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_HEADER_BYTE;
		cfg_data = '0;
		in_valid = 1'b0;
		mode = MODE_BYTE;
		rx_byte = 8'h00;
		out_stall = 1'b0;

		// Shadow starts at the reset values
		want_hdr = HEADER_RST;
		want_end = END_RST;
		want_timeout = TIMEOUT_RST;
		dfr_phase = PH_WAIT_HDR;
		dfr_count = 0;
		for (int i = 0; i < PAY_LEN; i++)
			dfr_bytes[i] = 8'h00;
		image = '0;
		frames_ok = '0;
		last_ok_ms = '0;
		now_ms = '0;

		// Directed script on reset settings. Typed rows: the tick after reset (online right
		// away), bytes that are not a header, the header byte, a good frame, a wrong end byte,
		// an all-ones frame, a tick with a junk byte and an end byte outside a frame.
		row(MODE_TICK, 8'h00, 1, 32'h0, 32'd0, 32'd0, 1'b1, 1'b0, 1'b0);
		row(MODE_BYTE, 8'h00, 1, 32'h0, 32'd0, 32'd0, 1'b1, 1'b0, 1'b0);
		row(MODE_BYTE, 8'hFF, 1, 32'h0, 32'd0, 32'd0, 1'b1, 1'b0, 1'b0);
		row(MODE_BYTE, 8'hAA, 1, 32'h0, 32'd0, 32'd0, 1'b1, 1'b0, 1'b0);
		row(MODE_BYTE, 8'hFF, 0, '0, '0, '0, '0, '0, '0);
		// A tick in mid-payload must leave the deframer alone
		row(MODE_TICK, 8'h5A, 0, '0, '0, '0, '0, '0, '0);
		row(MODE_BYTE, 8'h00, 0, '0, '0, '0, '0, '0, '0);
		row(MODE_BYTE, 8'h80, 0, '0, '0, '0, '0, '0, '0);
		row(MODE_BYTE, 8'h01, 0, '0, '0, '0, '0, '0, '0);
		row(MODE_BYTE, 8'h55, 1, 32'h018000FF, 32'd1, 32'd2, 1'b1, 1'b1, 1'b0);
		row(MODE_BYTE, 8'hAA, 0, '0, '0, '0, '0, '0, '0);
		row(MODE_BYTE, 8'h12, 0, '0, '0, '0, '0, '0, '0);
		row(MODE_BYTE, 8'h34, 0, '0, '0, '0, '0, '0, '0);
		row(MODE_BYTE, 8'h56, 0, '0, '0, '0, '0, '0, '0);
		row(MODE_BYTE, 8'h78, 0, '0, '0, '0, '0, '0, '0);
		row(MODE_BYTE, 8'h54, 1, 32'h018000FF, 32'd1, 32'd2, 1'b1, 1'b0, 1'b1);
		row(MODE_BYTE, 8'hAA, 0, '0, '0, '0, '0, '0, '0);
		row(MODE_BYTE, 8'hFF, 0, '0, '0, '0, '0, '0, '0);
		row(MODE_BYTE, 8'hFF, 0, '0, '0, '0, '0, '0, '0);
		row(MODE_BYTE, 8'hFF, 0, '0, '0, '0, '0, '0, '0);
		row(MODE_BYTE, 8'hFF, 0, '0, '0, '0, '0, '0, '0);
		row(MODE_BYTE, 8'h55, 1, 32'hFFFFFFFF, 32'd2, 32'd2, 1'b1, 1'b1, 1'b0);
		row(MODE_TICK, 8'hFF, 1, 32'hFFFFFFFF, 32'd2, 32'd2, 1'b1, 1'b0, 1'b0);
		row(MODE_BYTE, 8'h55, 1, 32'hFFFFFFFF, 32'd2, 32'd2, 1'b1, 1'b0, 1'b0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i])
			send_item(script[i].m, script[i].b, script[i].typed, script[i].want);

		// Reset settings, with a long receiver hold-off to back the block up
		run_traffic(PHASE_ITEMS, 1, 0);

		// Header zero, end all ones, shortest window; junk upper data bits must be dropped
		settle();
		write_reg(REG_HEADER_BYTE, {8'($urandom), 8'h00});
		write_reg(REG_END_BYTE, {8'($urandom), 8'hFF});
		write_reg(REG_TIMEOUT_MS, 16'd1);
		write_reg(REG_UNUSED, 16'($urandom));
		run_traffic(PHASE_ITEMS, 0, 1);

		// Header all ones, end zero, widest window
		settle();
		write_reg(REG_HEADER_BYTE, {8'($urandom), 8'hFF});
		write_reg(REG_END_BYTE, {8'($urandom), 8'h00});
		write_reg(REG_TIMEOUT_MS, 16'hFFFF);
		run_traffic(PHASE_ITEMS, 0, 0);

		// Zero timeout: never online
		settle();
		write_reg(REG_HEADER_BYTE, 16'($urandom));
		write_reg(REG_END_BYTE, 16'($urandom));
		write_reg(REG_TIMEOUT_MS, 16'd0);
		run_traffic(PHASE_ITEMS, 1, 0);

		// Header and end byte equal, short window so online drops often
		settle();
		begin
			logic [7:0] same;
			same = 8'($urandom);
			write_reg(REG_HEADER_BYTE, {8'($urandom), same});
			write_reg(REG_END_BYTE, {8'($urandom), same});
		end
		write_reg(REG_TIMEOUT_MS, 16'($urandom_range(2, 40)));
		run_traffic(PHASE_ITEMS, 0, 0);

		// Back to the reset bytes with a random window; a stray write must not disturb it
		settle();
		write_reg(REG_HEADER_BYTE, {8'($urandom), HEADER_RST});
		write_reg(REG_END_BYTE, {8'($urandom), END_RST});
		write_reg(REG_TIMEOUT_MS, 16'($urandom_range(1, 65535)));
		write_reg(REG_UNUSED, 16'($urandom));
		run_traffic(PHASE_ITEMS, 0, 0);

		// Drain, then linger so any extra result would be caught
		settle();
		repeat (10) @(posedge clk);
		if (pending_status.size() != 0)
			report_bad("results never seen", 32'(pending_status.size()), '0);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

/* filelist.f */
src/fgd_pkg.sv
src/fixed_frame_gpio_deframer.sv
tb/tb_fixed_frame_gpio_deframer.sv
